// ===== rtl/cgl_pkg.sv =====
// Shared types, constants and helpers of the colour gradient lookup.
package cgl_pkg;

	localparam int NUM_STOP_REGS = 7;
	localparam int DEF_MAX_STOPS = 7;
	localparam int LOC_FRAC      = 12;
	localparam int LOC_W         = LOC_FRAC + 1;
	localparam int LOC_LSB       = 32;
	localparam int QUERY_LOC_W   = 16;
	localparam int STOP_W        = 45;
	localparam int COLOR_W       = 32;
	localparam int CH_W          = 8;
	localparam int NUM_CH        = 4;
	localparam int NUM_W         = LOC_W + CH_W;
	localparam int DIV_STEPS     = CH_W;
	localparam int IDX_W         = 3;
	localparam int CNT_W         = 3;
	localparam int CFG_IDX_W     = 4;

	localparam logic [LOC_W-1:0]     LOC_ONE        = LOC_W'(1) << LOC_FRAC;
	localparam logic [CNT_W-1:0]     STOP_COUNT_RST = CNT_W'(2);
	localparam logic [CH_W-1:0]      ALPHA_OPAQUE   = '1;

	// register indexes of the write port
	localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_STOP_FIRST = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_STOP_LAST  = CFG_IDX_W'(NUM_STOP_REGS);

	typedef enum logic [1:0] {
		MODE_DIRECT = 2'd0,
		MODE_LERP   = 2'd1,
		MODE_NONE   = 2'd2
	} cgl_mode_t;

	typedef struct packed {
		logic valid;
		logic found;
	} cgl_tag_t;

	// location of stop k: first stop pinned to 0, last stop in use pinned to 1.0
	function automatic logic [LOC_W-1:0] loc_at(
		input logic [IDX_W-1:0]  k,
		input logic [IDX_W-1:0]  last,
		input logic [STOP_W-1:0] word
	);
		logic [LOC_W-1:0] loc;
		if (k == '0) begin
			loc = '0;
		end else if (k == last) begin
			loc = LOC_ONE;
		end else begin
			loc = word[LOC_LSB +: LOC_W];
		end
		return loc;
	endfunction

endpackage

// ===== rtl/cgl_if.sv =====
// Query and colour channel interfaces of the colour gradient lookup.
interface cgl_query_if;
	import cgl_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [QUERY_LOC_W-1:0] location;
	logic                          include_alpha;

	modport source(output valid, location, include_alpha, input ready);
	modport sink(input valid, location, include_alpha, output ready);
endinterface

interface cgl_color_if;
	import cgl_pkg::*;

	logic            valid;
	logic            ready;
	logic [CH_W-1:0] red;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] blue;
	logic [CH_W-1:0] alpha;
	logic            found;

	modport source(output valid, red, green, blue, alpha, found, input ready);
	modport sink(input valid, red, green, blue, alpha, found, output ready);
endinterface

// ===== rtl/color_gradient_lookup.sv =====
// Top level of the colour gradient lookup: stop registers, search, weights and output.
//
//  channel  | dir | handshake     | payload
//  query    | in  | valid/ready   | location (s16, Q.12), include_alpha
//  color    | out | valid/ready   | red, green, blue, alpha, found
//  wr_*     | in  | wr_en only    | wr_index (0 count, 1..7 stops), wr_data (45 b)
//
// Stages: clamp, stop search, weight fetch, multiply, then eight divider
// stages, one quotient bit each. One item per cycle when the colour side is ready.
// A stall at the output holds every stage; the last divider stage is the output register.
// Reset clears the valid bits, sets stop_count to 2 and every stop word to 0.
module color_gradient_lookup #(
	parameter int MAX_STOPS = cgl_pkg::DEF_MAX_STOPS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [cgl_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [cgl_pkg::STOP_W-1:0]       wr_data,
	cgl_query_if.sink                        query,
	cgl_color_if.source                      color
);
	import cgl_pkg::*;

	// configuration
	logic [CNT_W-1:0]  stop_count_q;
	logic [STOP_W-1:0] stop_word_q [NUM_STOP_REGS];
	logic [CNT_W-1:0]  n_used;
	logic [IDX_W-1:0]  n_last;

	// pipeline
	logic              en;
	logic [LOC_W-1:0]  x_in;
	logic              v_s1, ia_s1;
	logic [LOC_W-1:0]  x_s1;
	logic              v_s2, ia_s2;
	logic [LOC_W-1:0]  x_s2;
	cgl_mode_t         mode_s2;
	logic [IDX_W-1:0]  lidx_s2;
	logic              v_s3, found_s3, a255_s3;
	logic [LOC_W-1:0]  span_s3, wl_s3, wr_s3;
	logic [COLOR_W-1:0] cl_s3, cr_s3;
	cgl_tag_t          tag_s4;
	logic [NUM_W-1:0]  num_s4 [NUM_CH];
	logic [LOC_W-1:0]  span_s4;

	// search
	cgl_mode_t         mode_d;
	logic [IDX_W-1:0]  lidx_d;
	logic              hit_any, hit_eq;
	logic [IDX_W-1:0]  hit_idx;
	logic [LOC_W-1:0]  lo_loc, hi_loc;

	// weight fetch
	logic [IDX_W-1:0]  ridx;
	logic [STOP_W-1:0] word_l, word_r;
	logic [LOC_W-1:0]  xl, xr;
	logic [LOC_W-1:0]  span_d, wl_d, wr_d;
	logic [COLOR_W-1:0] cl_d, cr_d;

	// divider
	logic [NUM_W-1:0]  num_d [NUM_CH];
	cgl_tag_t          tag_out;
	logic [CH_W-1:0]   quo_out [NUM_CH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_count_q <= STOP_COUNT_RST;
			stop_word_q  <= '{default: '0};
		end else if (wr_en) begin
			if (wr_index == REG_STOP_COUNT) begin
				stop_count_q <= wr_data[CNT_W-1:0];
			end else if (wr_index <= REG_STOP_LAST) begin
				stop_word_q[IDX_W'(wr_index - REG_STOP_FIRST)] <= wr_data;
			end
		end
	end

	always_comb begin
		if (stop_count_q == '0) begin
			n_used = CNT_W'(1);
		end else if (stop_count_q > CNT_W'(MAX_STOPS)) begin
			n_used = CNT_W'(MAX_STOPS);
		end else begin
			n_used = stop_count_q;
		end
		n_last = n_used - CNT_W'(1);
	end

	assign en          = !tag_out.valid || color.ready;
	assign query.ready = en;

	// stage 1: clamp to 0..1.0
	always_comb begin
		if (query.location[QUERY_LOC_W-1]) begin
			x_in = '0;
		end else if (query.location[QUERY_LOC_W-2:0] > (QUERY_LOC_W-1)'(LOC_ONE)) begin
			x_in = LOC_ONE;
		end else begin
			x_in = query.location[LOC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= query.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= x_in;
			ia_s1 <= query.include_alpha;
		end
	end

	// stage 2: search the segments, the lowest one that matches wins
	always_comb begin
		hit_any = 1'b0;
		hit_eq  = 1'b0;
		hit_idx = '0;
		lo_loc  = '0;
		hi_loc  = '0;
		for (int i = MAX_STOPS - 1; i >= 1; i--) begin
			lo_loc = loc_at(IDX_W'(i - 1), n_last, stop_word_q[i-1]);
			hi_loc = loc_at(IDX_W'(i), n_last, stop_word_q[i]);
			if (IDX_W'(i) < n_used) begin
				if (hi_loc == x_s1 || (lo_loc < x_s1 && x_s1 < hi_loc)) begin
					hit_any = 1'b1;
					hit_eq  = (hi_loc == x_s1);
					hit_idx = IDX_W'(i);
				end
			end
		end

		if (n_used == CNT_W'(1) || x_s1 == '0) begin
			mode_d = MODE_DIRECT;
			lidx_d = '0;
		end else if (x_s1 == LOC_ONE) begin
			mode_d = MODE_DIRECT;
			lidx_d = n_last;
		end else if (hit_any && hit_eq) begin
			mode_d = MODE_DIRECT;
			lidx_d = hit_idx;
		end else if (hit_any) begin
			mode_d = MODE_LERP;
			lidx_d = hit_idx - IDX_W'(1);
		end else begin
			mode_d = MODE_NONE;
			lidx_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2    <= x_s1;
			ia_s2   <= ia_s1;
			mode_s2 <= mode_d;
			lidx_s2 <= lidx_d;
		end
	end

	// stage 3: fetch the bracketing stops and form the weights
	assign ridx   = (mode_s2 == MODE_LERP) ? lidx_s2 + IDX_W'(1) : lidx_s2;
	assign word_l = stop_word_q[lidx_s2];
	assign word_r = stop_word_q[ridx];
	assign xl     = loc_at(lidx_s2, n_last, word_l);
	assign xr     = loc_at(ridx, n_last, word_r);

	always_comb begin
		unique case (mode_s2)
			MODE_LERP: begin
				span_d = xr - xl;
				wl_d   = xr - x_s2;
				wr_d   = x_s2 - xl;
				cl_d   = word_l[COLOR_W-1:0];
				cr_d   = word_r[COLOR_W-1:0];
			end
			MODE_DIRECT: begin
				// a unit divisor passes the stop colour straight through
				span_d = LOC_W'(1);
				wl_d   = LOC_W'(1);
				wr_d   = '0;
				cl_d   = word_l[COLOR_W-1:0];
				cr_d   = '0;
			end
			default: begin
				span_d = LOC_W'(1);
				wl_d   = '0;
				wr_d   = '0;
				cl_d   = '0;
				cr_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			span_s3  <= span_d;
			wl_s3    <= wl_d;
			wr_s3    <= wr_d;
			cl_s3    <= cl_d;
			cr_s3    <= cr_d;
			found_s3 <= (mode_s2 != MODE_NONE);
			a255_s3  <= (mode_s2 == MODE_LERP) && !ia_s2;
		end
	end

	// stage 4: weighted sums; opaque alpha becomes 255 * span over span
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			num_d[c] = NUM_W'(cl_s3[(NUM_CH-1-c)*CH_W +: CH_W]) * NUM_W'(wl_s3)
				+ NUM_W'(cr_s3[(NUM_CH-1-c)*CH_W +: CH_W]) * NUM_W'(wr_s3);
		end
		if (a255_s3) begin
			num_d[NUM_CH-1] = NUM_W'({span_s3, CH_W'(0)}) - NUM_W'(span_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s4 <= '0;
		end else if (en) begin
			tag_s4.valid <= v_s3;
			tag_s4.found <= found_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			span_s4 <= span_s3;
			for (int c = 0; c < NUM_CH; c++) begin
				num_s4[c] <= num_d[c];
			end
		end
	end

	cgl_div_pipe u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.tag_in  (tag_s4),
		.num_in  (num_s4),
		.span_in (span_s4),
		.tag_out (tag_out),
		.quo_out (quo_out)
	);

	assign color.valid = tag_out.valid;
	assign color.found = tag_out.found;
	assign color.red   = quo_out[0];
	assign color.green = quo_out[1];
	assign color.blue  = quo_out[2];
	assign color.alpha = quo_out[3];

`ifndef SYNTH
	a_none_is_black: assert property (@(posedge clk) disable iff (!arst_n)
		color.valid && !color.found |->
			color.red == '0 && color.green == '0 && color.blue == '0 && color.alpha == '0)
		else $error("item without a segment carries a colour");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		color.valid && !color.ready |-> !query.ready)
		else $error("query taken while the output is stalled");

	a_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> x_s1 <= LOC_ONE)
		else $error("clamped location above 1.0");

	a_weights_sum: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && found_s3 |->
			(({1'b0, wl_s3} + {1'b0, wr_s3}) == {1'b0, span_s3}) && span_s3 != '0)
		else $error("weights do not add up to the segment span");
`endif

endmodule

// ===== rtl/cgl_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, four channels on a shared divisor.
module cgl_div_pipe (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  cgl_pkg::cgl_tag_t            tag_in,
	input  logic [cgl_pkg::NUM_W-1:0]    num_in [cgl_pkg::NUM_CH],
	input  logic [cgl_pkg::LOC_W-1:0]    span_in,
	output cgl_pkg::cgl_tag_t            tag_out,
	output logic [cgl_pkg::CH_W-1:0]     quo_out [cgl_pkg::NUM_CH]
);
	import cgl_pkg::*;

	cgl_tag_t         tag_s  [DIV_STEPS];
	logic [CH_W-1:0]  quo_s  [DIV_STEPS][NUM_CH];
	logic [NUM_W-1:0] rem_s  [DIV_STEPS-1][NUM_CH];
	logic [LOC_W-1:0] span_s [DIV_STEPS-1];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		localparam int B = CH_W - 1 - k;

		cgl_tag_t         tag_k;
		logic [CH_W-1:0]  quo_k [NUM_CH];
		logic [NUM_W-1:0] rem_k [NUM_CH];
		logic [LOC_W-1:0] span_k;
		logic [NUM_W-1:0] dvs;
		logic [NUM_CH-1:0] take;

		if (k == 0) begin : g_first
			always_comb begin
				tag_k  = tag_in;
				span_k = span_in;
				for (int c = 0; c < NUM_CH; c++) begin
					quo_k[c] = '0;
					rem_k[c] = num_in[c];
				end
			end
		end else begin : g_next
			always_comb begin
				tag_k  = tag_s[k-1];
				span_k = span_s[k-1];
				for (int c = 0; c < NUM_CH; c++) begin
					quo_k[c] = quo_s[k-1][c];
					rem_k[c] = rem_s[k-1][c];
				end
			end
		end

		assign dvs = NUM_W'(span_k) << B;

		always_comb begin
			for (int c = 0; c < NUM_CH; c++) begin
				take[c] = (rem_k[c] >= dvs);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k] <= '0;
			end else if (en) begin
				tag_s[k] <= tag_k;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int c = 0; c < NUM_CH; c++) begin
					quo_s[k][c] <= {quo_k[c][CH_W-2:0], take[c]};
				end
			end
		end

		// the last stage only needs the quotient
		if (k < DIV_STEPS - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					span_s[k] <= span_k;
					for (int c = 0; c < NUM_CH; c++) begin
						rem_s[k][c] <= take[c] ? rem_k[c] - dvs : rem_k[c];
					end
				end
			end
		end
	end

	assign tag_out = tag_s[DIV_STEPS-1];

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			quo_out[c] = quo_s[DIV_STEPS-1][c];
		end
	end

endmodule
